// ===== src/afse_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afse_pkg
// Shared types, codes and constants of the converter post-processing block.
// ----------------------------------------------------------------------------
package afse_pkg;

  // Item kinds
  localparam logic FUNC_MEASURE = 1'b0;
  localparam logic FUNC_ENERGY  = 1'b1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_COEF    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITOR_COEF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPLY_COEF    = 2'd2;

  localparam int COEF_W = 16;
  localparam logic [COEF_W-1:0] ENERGY_COEF_RST    = 16'd1401;
  localparam logic [COEF_W-1:0] CAPACITOR_COEF_RST = 16'd10932;
  localparam logic [COEF_W-1:0] SUPPLY_COEF_RST    = 16'd8800;

  localparam int FAST_W = 8;
  localparam int BYTE_W = 8;

  // Shared multiplier: signed A times unsigned coefficient
  localparam int MUL_A_W = 17;
  localparam int PROD_W  = MUL_A_W + COEF_W;
  localparam int SCALE_SHIFT = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_MUL1,
    ST_MUL2,
    ST_FIN
  } afse_state_t;

  typedef enum logic [1:0] {
    OP_CAP,
    OP_SUP,
    OP_SQUARE,
    OP_ENERGY
  } afse_op_t;

  typedef struct packed {
    logic     in_ready;
    logic     filt_upd;
    logic     mul_en;
    afse_op_t op;
    logic     held_cap_we;
    logic     load_out;
  } afse_ctl_t;

  // Scale product: floor shift by 16, then clip to one byte
  function automatic logic [BYTE_W-1:0] clip_prod(input logic signed [PROD_W-1:0] p);
    logic [BYTE_W-1:0] r;
    if (p[PROD_W-1]) begin
      r = '0;
    end else if (|p[PROD_W-2:SCALE_SHIFT+BYTE_W]) begin
      r = '1;
    end else begin
      r = p[SCALE_SHIFT+BYTE_W-1:SCALE_SHIFT];
    end
    return r;
  endfunction

endpackage

// ===== src/afse_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afse_if
// Valid/ready channels: input items, result items and register writes.
// ----------------------------------------------------------------------------
interface afse_in_if #(parameter int SAMPLE_BITS = 12);
  logic                          valid;
  logic                          ready;
  logic                          func;
  logic signed [SAMPLE_BITS-1:0] capacitor_sample;
  logic signed [SAMPLE_BITS-1:0] supply_sample;
  logic                          prime;
  logic signed [7:0]             fast_sample;

  modport source (output valid, func, capacitor_sample, supply_sample, prime,
                  fast_sample, input ready);
  modport sink (input valid, func, capacitor_sample, supply_sample, prime,
                fast_sample, output ready);
endinterface

interface afse_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] capacitor_volts;
  logic [7:0] supply_volts;
  logic [7:0] energy;

  modport source (output valid, capacitor_volts, supply_volts, energy, input ready);
  modport sink (input valid, capacitor_volts, supply_volts, energy, output ready);
endinterface

interface afse_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/afse_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// afse_mul
// Shared multiplier: signed operand times unsigned coefficient, registered.
// ----------------------------------------------------------------------------
module afse_mul (
  input  logic                                  clk,
  input  logic                                  en,
  input  logic signed [afse_pkg::MUL_A_W-1:0]   a,
  input  logic        [afse_pkg::COEF_W-1:0]    b,
  output logic signed [afse_pkg::PROD_W-1:0]    prod
);
  import afse_pkg::*;

  logic signed [PROD_W-1:0] full;

  // Widen the coefficient with a zero sign bit; the product fits PROD_W bits
  assign full = a * $signed({1'b0, b});

  // Hold the product until the next enabled step
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= full;
    end
  end

endmodule

// ===== src/adc_filter_scale_energy.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// adc_filter_scale_energy
// Filters capacitor and supply samples, scales them to voltage bytes, and
// answers energy queries from the fast sample, on one shared multiplier.
// ----------------------------------------------------------------------------
//  channel  dir  beat contents
//  in_ch    in   func, capacitor_sample, supply_sample, prime, fast_sample
//  out_ch   out  capacitor_volts, supply_volts, energy
//  cfg_ch   in   index, data (coefficient write)
//
//  A measure item goes through filter update, two multiplier passes and finish
//  before its result loads; an energy query goes through square, scale and
//  finish. Both kinds share the single multiplier.
//  Reset restores the coefficients and clears filters and held bytes.
//  The input is not ready while an item is at work; a stalled result waits in
//  the output register, and a new item may be accepted meanwhile.
// ----------------------------------------------------------------------------
module adc_filter_scale_energy #(
  parameter int SAMPLE_BITS = 12
) (
  input  logic clk,
  input  logic rst,
  afse_in_if.sink    in_ch,
  afse_out_if.source out_ch,
  afse_cfg_if.sink   cfg_ch
);
  import afse_pkg::*;

  afse_state_t state, state_next;
  afse_ctl_t   ctl;

  // Coefficients
  logic [COEF_W-1:0] energy_coef, cap_coef, sup_coef;

  // Item registers
  logic                          item_func;
  logic                          item_prime;
  logic signed [SAMPLE_BITS-1:0] item_cap;
  logic signed [SAMPLE_BITS-1:0] item_sup;
  logic signed [FAST_W-1:0]      item_fast;

  // Filter and held state
  logic signed [SAMPLE_BITS-1:0] cap_filter, sup_filter;
  logic signed [SAMPLE_BITS-1:0] cap_filter_next, sup_filter_next;
  logic [BYTE_W-1:0]             held_cap, held_sup;

  logic signed [SAMPLE_BITS:0]   cap_sum;
  logic signed [SAMPLE_BITS+3:0] sup_sum;

  logic signed [MUL_A_W-1:0] mul_a;
  logic        [COEF_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic [BYTE_W-1:0]         prod_byte;
  logic                      fast_pos;

  logic in_acc;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = ctl.in_ready;
  assign in_acc       = in_ch.valid & ctl.in_ready;
  assign prod_byte    = clip_prod(prod);
  assign fast_pos     = !item_fast[FAST_W-1] && (|item_fast);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (in_ch.func == FUNC_ENERGY) ? ST_MUL1 : ST_FILT;
        end
      end
      ST_FILT: state_next = ST_MUL1;
      ST_MUL1: state_next = ST_MUL2;
      ST_MUL2: state_next = ST_FIN;
      ST_FIN: begin
        if (!out_ch.valid || out_ch.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl = '0;
    ctl.op = OP_CAP;
    case (state)
      ST_IDLE: ctl.in_ready = 1'b1;
      ST_FILT: ctl.filt_upd = 1'b1;
      ST_MUL1: begin
        ctl.mul_en = 1'b1;
        ctl.op     = (item_func == FUNC_ENERGY) ? OP_SQUARE : OP_CAP;
      end
      ST_MUL2: begin
        ctl.mul_en      = 1'b1;
        ctl.op          = (item_func == FUNC_ENERGY) ? OP_ENERGY : OP_SUP;
        ctl.held_cap_we = (item_func == FUNC_MEASURE);
      end
      ST_FIN: ctl.load_out = !out_ch.valid || out_ch.ready;
      default: ctl = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Coefficient writes; unknown index is dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      energy_coef <= ENERGY_COEF_RST;
      cap_coef    <= CAPACITOR_COEF_RST;
      sup_coef    <= SUPPLY_COEF_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_ENERGY_COEF:    energy_coef <= cfg_ch.data;
        CFG_CAPACITOR_COEF: cap_coef    <= cfg_ch.data;
        CFG_SUPPLY_COEF:    sup_coef    <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  // Capture the item beat
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_func  <= in_ch.func;
      item_prime <= in_ch.prime;
      item_cap   <= in_ch.capacitor_sample;
      item_sup   <= in_ch.supply_sample;
      item_fast  <= in_ch.fast_sample;
    end
  end

  // Filter update: rounded mean and 7/8 leak, floor shifts; prime loads the sample
  always_comb begin
    cap_sum = {cap_filter[SAMPLE_BITS-1], cap_filter}
            + {item_cap[SAMPLE_BITS-1], item_cap}
            + (SAMPLE_BITS+1)'(1);
    sup_sum = ((SAMPLE_BITS+4)'(sup_filter) <<< 3) - (SAMPLE_BITS+4)'(sup_filter)
            + (SAMPLE_BITS+4)'(item_sup) + (SAMPLE_BITS+4)'(4);
    if (item_prime) begin
      cap_filter_next = item_cap;
      sup_filter_next = item_sup;
    end else begin
      cap_filter_next = cap_sum[SAMPLE_BITS:1];
      sup_filter_next = sup_sum[SAMPLE_BITS+2:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_filter <= '0;
      sup_filter <= '0;
    end else if (ctl.filt_upd) begin
      cap_filter <= cap_filter_next;
      sup_filter <= sup_filter_next;
    end
  end

  // Select multiplier operands
  always_comb begin
    case (ctl.op)
      OP_CAP: begin
        mul_a = MUL_A_W'(cap_filter);
        mul_b = cap_coef;
      end
      OP_SUP: begin
        mul_a = MUL_A_W'(sup_filter);
        mul_b = sup_coef;
      end
      OP_SQUARE: begin
        mul_a = MUL_A_W'(item_fast);
        mul_b = {{(COEF_W-FAST_W){1'b0}}, item_fast};
      end
      OP_ENERGY: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = energy_coef;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  afse_mul u_mul (
    .clk  (clk),
    .en   (ctl.mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Held voltage bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      held_cap <= '0;
      held_sup <= '0;
    end else begin
      if (ctl.held_cap_we) begin
        held_cap <= prod_byte;
      end
      if (ctl.load_out && item_func == FUNC_MEASURE) begin
        held_sup <= prod_byte;
      end
    end
  end

  // Output register: load the result beat, drop it when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (ctl.load_out) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_out) begin
      out_ch.capacitor_volts <= held_cap;
      if (item_func == FUNC_MEASURE) begin
        out_ch.supply_volts <= prod_byte;
        out_ch.energy       <= '0;
      end else begin
        out_ch.supply_volts <= held_sup;
        out_ch.energy       <= fast_pos ? prod_byte : '0;
      end
    end
  end

endmodule
